FILE: hw/rtl/mpi_pkg.sv
// Package for the modular power and inverse block: field widths, op codes,
// microcode word layout and the microcode program.
// No dependencies.
`default_nettype none

package mpi_pkg;

	localparam int MOD_WIDTH_DEF = 31;
	localparam int EXP_WIDTH_DEF = 63;

	localparam int OPV_W  = 1;
	localparam int BASE_W = 63;
	localparam int EXPV_W = 63;
	localparam int MODV_W = 31;
	localparam int RES_W  = 31;

	localparam logic [OPV_W-1:0] OP_POW = 1'b0;
	localparam logic [OPV_W-1:0] OP_INV = 1'b1;

	localparam int PC_W = 5;

	typedef enum logic [3:0] {
		DP_IDLE,
		DP_NOP,
		DP_BRED,
		DP_NORM,
		DP_SETUP,
		DP_MUDIV,
		DP_MULP,
		DP_MULQ,
		DP_MULR,
		DP_SUBR,
		DP_FIX,
		DP_FIN
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_IDLE,
		C_SMALL,
		C_LOOP,
		C_NORM,
		C_TEST,
		C_OUT
	} cond_t;

	typedef enum logic {
		DST_ACC,
		DST_SQ
	} dst_t;

	typedef struct packed {
		dp_op_t          op;
		cond_t           cond;
		dst_t            dst;
		logic [PC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic in_fire;
		logic m_small;
		logic m_norm;
		logic cnt_last;
		logic e_zero;
		logic e_lsb;
		logic out_free;
	} seq_st_t;

	localparam logic [PC_W-1:0] ADDR_IDLE  = 5'd0;
	localparam logic [PC_W-1:0] ADDR_CHK   = 5'd1;
	localparam logic [PC_W-1:0] ADDR_BRED  = 5'd2;
	localparam logic [PC_W-1:0] ADDR_NORM  = 5'd3;
	localparam logic [PC_W-1:0] ADDR_SETUP = 5'd4;
	localparam logic [PC_W-1:0] ADDR_MU    = 5'd5;
	localparam logic [PC_W-1:0] ADDR_TEST  = 5'd6;
	localparam logic [PC_W-1:0] ADDR_A1    = 5'd7;
	localparam logic [PC_W-1:0] ADDR_A2    = 5'd8;
	localparam logic [PC_W-1:0] ADDR_A3    = 5'd9;
	localparam logic [PC_W-1:0] ADDR_A4    = 5'd10;
	localparam logic [PC_W-1:0] ADDR_A5    = 5'd11;
	localparam logic [PC_W-1:0] ADDR_S1    = 5'd12;
	localparam logic [PC_W-1:0] ADDR_S2    = 5'd13;
	localparam logic [PC_W-1:0] ADDR_S3    = 5'd14;
	localparam logic [PC_W-1:0] ADDR_S4    = 5'd15;
	localparam logic [PC_W-1:0] ADDR_S5    = 5'd16;
	localparam logic [PC_W-1:0] ADDR_FIN   = 5'd17;

	function automatic ucw_t uw(input dp_op_t o, input cond_t c, input dst_t d,
		input logic [PC_W-1:0] t);
		ucw_t w;
		w.op = o;
		w.cond = c;
		w.dst = d;
		w.target = t;
		return w;
	endfunction

	function automatic ucw_t ucode(input logic [PC_W-1:0] a);
		ucw_t w;
		unique case (a)
			ADDR_IDLE:  w = uw(DP_IDLE,  C_IDLE,  DST_ACC, ADDR_IDLE);
			ADDR_CHK:   w = uw(DP_NOP,   C_SMALL, DST_ACC, ADDR_FIN);
			ADDR_BRED:  w = uw(DP_BRED,  C_LOOP,  DST_ACC, ADDR_BRED);
			ADDR_NORM:  w = uw(DP_NORM,  C_NORM,  DST_ACC, ADDR_NORM);
			ADDR_SETUP: w = uw(DP_SETUP, C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_MU:    w = uw(DP_MUDIV, C_LOOP,  DST_ACC, ADDR_MU);
			ADDR_TEST:  w = uw(DP_NOP,   C_TEST,  DST_ACC, ADDR_S1);
			ADDR_A1:    w = uw(DP_MULP,  C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_A2:    w = uw(DP_MULQ,  C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_A3:    w = uw(DP_MULR,  C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_A4:    w = uw(DP_SUBR,  C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_A5:    w = uw(DP_FIX,   C_NEXT,  DST_ACC, ADDR_IDLE);
			ADDR_S1:    w = uw(DP_MULP,  C_NEXT,  DST_SQ,  ADDR_IDLE);
			ADDR_S2:    w = uw(DP_MULQ,  C_NEXT,  DST_SQ,  ADDR_IDLE);
			ADDR_S3:    w = uw(DP_MULR,  C_NEXT,  DST_SQ,  ADDR_IDLE);
			ADDR_S4:    w = uw(DP_SUBR,  C_NEXT,  DST_SQ,  ADDR_IDLE);
			ADDR_S5:    w = uw(DP_FIX,   C_JUMP,  DST_SQ,  ADDR_TEST);
			ADDR_FIN:   w = uw(DP_FIN,   C_OUT,   DST_ACC, ADDR_IDLE);
			default:    w = uw(DP_IDLE,  C_JUMP,  DST_ACC, ADDR_IDLE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpi_seq.sv
// Microcode sequencer: step counter, program ROM and branch logic.
// Depends on mpi_pkg for the control word, status struct and program.
`default_nettype none

module mpi_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mpi_pkg::seq_st_t st,
	output mpi_pkg::ucw_t        cw
);
	import mpi_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_inc;
	logic [PC_W-1:0] pc_nx;

	assign cw     = ucode(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		unique case (cw.cond)
			C_NEXT:  pc_nx = pc_inc;
			C_JUMP:  pc_nx = cw.target;
			C_IDLE:  pc_nx = st.in_fire ? pc_inc : pc_q;
			C_SMALL: pc_nx = st.m_small ? cw.target : pc_inc;
			C_LOOP:  pc_nx = st.cnt_last ? pc_inc : pc_q;
			C_NORM:  pc_nx = st.m_norm ? pc_inc : pc_q;
			C_TEST: begin
				if (st.e_zero)
					pc_nx = ADDR_FIN;
				else if (!st.e_lsb)
					pc_nx = cw.target;
				else
					pc_nx = pc_inc;
			end
			C_OUT:   pc_nx = st.out_free ? cw.target : pc_q;
			default: pc_nx = ADDR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= ADDR_IDLE;
		else
			pc_q <= pc_nx;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/modular_power_and_inverse.sv
// Modular power and Fermat inverse by right-to-left square-and-multiply,
// microcoded datapath with one shared multiplier and Barrett reduction.
// Depends on mpi_pkg and mpi_seq.
//
//   channel  handshake            words
//   in       in_valid / in_stall  op, base_value, exponent_value, modulus_value
//   out      out_valid / out_stall result_value
//
// Steps per word: accept, modulus check, base reduction (one bit a cycle),
// modulus normalization, setup, reciprocal division, then per exponent bit
// up to its highest set bit a multiply (only when the bit is set) and a square,
// then the final exponent test and the hand-off; the shared multiplier and
// the step-by-step program set the pace.
// A modulus below two skips straight to the hand-off.
// Reset clears the step counter and the output valid; no clearing pass.
// The next word is taken once the previous result sits in the output
// register, which holds it under out_stall.
`default_nettype none

module modular_power_and_inverse #(
	parameter int MOD_WIDTH = mpi_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = mpi_pkg::EXP_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [mpi_pkg::OPV_W-1:0]   op,
	input  wire logic [mpi_pkg::BASE_W-1:0]  base_value,
	input  wire logic [mpi_pkg::EXPV_W-1:0]  exponent_value,
	input  wire logic [mpi_pkg::MODV_W-1:0]  modulus_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [mpi_pkg::RES_W-1:0]        result_value
);
	import mpi_pkg::*;

	localparam int K     = MOD_WIDTH;
	localparam int EW    = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
	localparam int SW    = $clog2(K);
	localparam int CNT_W = $clog2(BASE_W + 1);

	ucw_t    cw;
	seq_st_t st;

	logic [K-1:0]     m_q;
	logic [SW-1:0]    s_q;
	logic [K:0]       r_q;
	logic [BASE_W-1:0] n_q;
	logic [K+1:0]     mu_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EW-1:0]    e_q;
	logic [K-1:0]     acc_q;
	logic [K-1:0]     sq_q;
	logic [2*K+2:0]   prod_q;
	logic [K+1:0]     plo_q;
	logic [K+1:0]     red_q;
	logic             out_valid_q;
	logic [RES_W-1:0] out_res_q;

	logic             in_fire;
	logic             div_in;
	logic [K:0]       div_t;
	logic             div_ge;
	logic [K:0]       div_nx;
	logic [K-1:0]     mul_src;
	logic [K:0]       mul_x;
	logic [K+1:0]     mul_y;
	logic [2*K+2:0]   mul_p;
	logic [K+1:0]     sub_v;
	logic [K+1:0]     fix_m1;
	logic [K+1:0]     fix_m2;
	logic [K-1:0]     fix_v;
	logic [K-1:0]     m_in;
	logic [K-1:0]     m_in_less2;

	mpi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw)
	);

	assign in_stall = (cw.op != DP_IDLE);
	assign in_fire  = in_valid && !in_stall;

	assign st.in_fire  = in_fire;
	assign st.m_small  = (m_q[K-1:1] == '0);
	assign st.m_norm   = m_q[K-1];
	assign st.cnt_last = (cnt_q == CNT_W'(1));
	assign st.e_zero   = (e_q == '0);
	assign st.e_lsb    = e_q[0];
	assign st.out_free = !out_valid_q || !out_stall;

	assign m_in       = modulus_value[K-1:0];
	assign m_in_less2 = m_in - K'(2);

	assign div_in = (cw.op == DP_BRED) ? n_q[BASE_W-1] : 1'b0;
	assign div_t  = {r_q[K-1:0], div_in};
	assign div_ge = (div_t >= {1'b0, m_q});
	assign div_nx = div_ge ? (div_t - {1'b0, m_q}) : div_t;

	assign mul_src = (cw.dst == DST_ACC) ? acc_q : sq_q;

	always_comb begin
		unique case (cw.op)
			DP_MULP: begin
				mul_x = {1'b0, mul_src >> s_q};
				mul_y = {2'b00, sq_q};
			end
			DP_MULQ: begin
				mul_x = prod_q[2*K-1:K-1];
				mul_y = mu_q;
			end
			DP_MULR: begin
				mul_x = {1'b0, prod_q[2*K:K+1]};
				mul_y = {2'b00, m_q};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign mul_p = {{(K+2){1'b0}}, mul_x} * {{(K+1){1'b0}}, mul_y};

	assign sub_v  = plo_q - prod_q[K+1:0];
	assign fix_m1 = red_q - {2'b00, m_q};
	assign fix_m2 = red_q - {1'b0, m_q, 1'b0};

	always_comb begin
		if (red_q >= {1'b0, m_q, 1'b0})
			fix_v = fix_m2[K-1:0];
		else if (red_q >= {2'b00, m_q})
			fix_v = fix_m1[K-1:0];
		else
			fix_v = red_q[K-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_q   <= m_in;
			n_q   <= base_value;
			e_q   <= (op == OP_INV) ? EW'(m_in_less2) : EW'(exponent_value[EXP_WIDTH-1:0]);
			r_q   <= '0;
			s_q   <= '0;
			acc_q <= '0;
			cnt_q <= CNT_W'(BASE_W);
		end else begin
			unique case (cw.op) inside
				DP_BRED: begin
					r_q   <= div_nx;
					n_q   <= {n_q[BASE_W-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
				end
				DP_NORM: begin
					if (!m_q[K-1]) begin
						m_q <= {m_q[K-2:0], 1'b0};
						r_q <= {r_q[K-1:0], 1'b0};
						s_q <= s_q + SW'(1);
					end
				end
				DP_SETUP: begin
					sq_q  <= r_q[K-1:0];
					acc_q <= {{(K-1){1'b0}}, 1'b1} << s_q;
					r_q   <= {3'b001, {(K-2){1'b0}}};
					cnt_q <= CNT_W'(K + 2);
				end
				DP_MUDIV: begin
					r_q   <= div_nx;
					mu_q  <= {mu_q[K:0], div_ge};
					cnt_q <= cnt_q - CNT_W'(1);
				end
				DP_MULP: begin
					prod_q <= mul_p;
					plo_q  <= mul_p[K+1:0];
				end
				DP_MULQ, DP_MULR: begin
					prod_q <= mul_p;
				end
				DP_SUBR: begin
					red_q <= sub_v;
				end
				DP_FIX: begin
					if (cw.dst == DST_ACC) begin
						acc_q <= fix_v;
					end else begin
						sq_q <= fix_v;
						e_q  <= e_q >> 1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cw.op == DP_FIN && st.out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == DP_FIN && st.out_free)
			out_res_q <= RES_W'(acc_q >> s_q);
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("block took a word but did not go busy");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == DP_SETUP) |-> m_q[K-1])
		else $error("modulus not normalized at setup");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == DP_FIX) |-> (fix_v < m_q))
		else $error("reduction left a value not below the modulus");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == DP_FIN && st.out_free) |=> (out_valid && !in_stall))
		else $error("result not handed to the output register");

endmodule

`default_nettype wire

FILE: verif/mpi_checker.sv
// Checker for modular_power_and_inverse: watches both channels, predicts each
// result by square-and-multiply and compares it with the word that comes out.
// Depends on mpi_pkg.

module mpi_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [mpi_pkg::OPV_W-1:0]  op,
	input  logic [mpi_pkg::BASE_W-1:0] base_value,
	input  logic [mpi_pkg::EXPV_W-1:0] exponent_value,
	input  logic [mpi_pkg::MODV_W-1:0] modulus_value,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [mpi_pkg::RES_W-1:0]  result_value,
	output int                         fail_count,
	output int                         pending,
	output int                         checked_count
);

	typedef struct packed {
		logic [mpi_pkg::OPV_W-1:0]  op;
		logic [mpi_pkg::BASE_W-1:0] base;
		logic [mpi_pkg::EXPV_W-1:0] expo;
		logic [mpi_pkg::MODV_W-1:0] modulus;
		logic [mpi_pkg::RES_W-1:0]  residue;
	} power_job_t;

	power_job_t residue_q[$];

	function automatic logic [mpi_pkg::RES_W-1:0] power_residue(
		input logic [mpi_pkg::OPV_W-1:0] o,
		input logic [mpi_pkg::BASE_W-1:0] b,
		input logic [mpi_pkg::EXPV_W-1:0] e,
		input logic [mpi_pkg::MODV_W-1:0] m);
		longint unsigned mm;
		longint unsigned acc;
		longint unsigned sq;
		longint unsigned ex;
		mm = 64'(m);
		if (mm < 2)
			return '0;
		ex = (o == mpi_pkg::OP_INV) ? mm - 2 : longint'(e);
		acc = 1;
		sq = longint'(b) % mm;
		while (ex != 0) begin
			if (ex[0])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
			ex = ex >> 1;
		end
		return acc[mpi_pkg::RES_W-1:0];
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked_count = 0;
	end

	always @(posedge clk) begin
		power_job_t job;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (residue_q.size() == 0) begin
					note_failure($sformatf("result word %0d with nothing expected",
						result_value));
				end else begin
					job = residue_q.pop_front();
					checked_count++;
					if (result_value !== job.residue)
						note_failure($sformatf(
							"op %0d base %0h exp %0h mod %0d: expected %0d, got %0d",
							job.op, job.base, job.expo, job.modulus, job.residue,
							result_value));
				end
			end
			if (in_valid && !in_stall) begin
				job.op = op;
				job.base = base_value;
				job.expo = exponent_value;
				job.modulus = modulus_value;
				job.residue = power_residue(op, base_value, exponent_value, modulus_value);
				residue_q.insert(residue_q.size(), job);
			end
			pending = residue_q.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// Testbench top for modular_power_and_inverse: clock, reset, random stimulus
// with gaps and back-pressure, watchdog and verdict.
// Depends on mpi_pkg, modular_power_and_inverse and mpi_checker.

module tb_top;

	localparam int NUM_ITEMS   = 1500;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [mpi_pkg::OPV_W-1:0]  op;
	logic [mpi_pkg::BASE_W-1:0] base_value;
	logic [mpi_pkg::EXPV_W-1:0] exponent_value;
	logic [mpi_pkg::MODV_W-1:0] modulus_value;
	logic                       out_valid;
	logic                       out_stall;
	logic [mpi_pkg::RES_W-1:0]  result_value;

	int fail_count;
	int pending;
	int checked_count;

	bit hold_req;
	bit steady_send;
	int n_pow;
	int n_inv;
	int n_mod_small;
	int n_long_exp;

	modular_power_and_inverse i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus_value  (modulus_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value)
	);

	mpi_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus_value  (modulus_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked_count  (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 300);
	endfunction

	function automatic logic [mpi_pkg::BASE_W-1:0] random_bits(input int len);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (len == 0)
			return '0;
		return v[62:0] >> (63 - len);
	endfunction

	function automatic logic [mpi_pkg::MODV_W-1:0] known_prime(input int k);
		case (k)
			0:       return 31'd2;
			1:       return 31'd3;
			2:       return 31'd5;
			3:       return 31'd7;
			4:       return 31'd13;
			5:       return 31'd97;
			6:       return 31'd257;
			7:       return 31'd65537;
			8:       return 31'd1000003;
			9:       return 31'd998244353;
			10:      return 31'd1000000007;
			default: return 31'h7FFF_FFFF;
		endcase
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic send_word(input logic [mpi_pkg::OPV_W-1:0] o,
		input logic [mpi_pkg::BASE_W-1:0] b, input logic [mpi_pkg::EXPV_W-1:0] e,
		input logic [mpi_pkg::MODV_W-1:0] m);
		int gap;
		op = o;
		base_value = b;
		exponent_value = e;
		modulus_value = m;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (o == mpi_pkg::OP_INV)
			n_inv++;
		else
			n_pow++;
		if (m < 2)
			n_mod_small++;
		if (o == mpi_pkg::OP_POW && e[62:32] != 0)
			n_long_exp++;
		@(negedge clk);
		gap = steady_send ? 0 : idle_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			base_value = random_bits(63);
			op = ($urandom_range(0, 1) == 0) ? mpi_pkg::OP_POW : mpi_pkg::OP_INV;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic make_item(output logic [mpi_pkg::OPV_W-1:0] o,
		output logic [mpi_pkg::BASE_W-1:0] b, output logic [mpi_pkg::EXPV_W-1:0] e,
		output logic [mpi_pkg::MODV_W-1:0] m);
		int r;
		int w;
		logic [63:0] prod;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			m = known_prime($urandom_range(0, 11));
		end else if (r < 35) begin
			m = 31'($urandom_range(2, 16));
		end else if (r < 45) begin
			m = 31'd1 << $urandom_range(1, 30);
		end else if (r < 55) begin
			m = 31'($urandom);
			if (m < 2)
				m = 31'd2;
		end else begin
			w = $urandom_range(2, 31);
			m = 31'((32'h8000_0000 | $urandom) >> (32 - w));
		end
		o = ($urandom_range(0, 99) < 30) ? mpi_pkg::OP_INV : mpi_pkg::OP_POW;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			b = '0;
		end else if (r < 16) begin
			prod = 64'(m) * 64'($urandom);
			b = prod[62:0];
		end else if (r < 22) begin
			b = '1;
		end else if (r < 28) begin
			b = 63'(m) - 63'($urandom_range(0, 1));
		end else begin
			b = random_bits($urandom_range(0, 63));
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			e = '0;
		else if (r < 10)
			e = '1;
		else if (r < 55)
			e = random_bits($urandom_range(1, 12));
		else if (r < 85)
			e = random_bits($urandom_range(13, 32));
		else
			e = random_bits($urandom_range(33, 63));
	endtask

	initial begin
		int r;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					out_stall = 1'b0;
					repeat ($urandom_range(50, 400)) @(negedge clk);
				end else if (r < 55) begin
					out_stall = 1'b0;
				end else begin
					out_stall = 1'b1;
					repeat (idle_len()) @(negedge clk);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no word accepted for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, pending);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [mpi_pkg::OPV_W-1:0]  o;
		logic [mpi_pkg::BASE_W-1:0] b;
		logic [mpi_pkg::EXPV_W-1:0] e;
		logic [mpi_pkg::MODV_W-1:0] m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = mpi_pkg::OP_POW;
		base_value = '0;
		exponent_value = '0;
		modulus_value = 31'd2;
		hold_req = 1'b0;
		steady_send = 1'b0;
		n_pow = 0;
		n_inv = 0;
		n_mod_small = 0;
		n_long_exp = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(mpi_pkg::OP_POW, 63'd0, 63'd0, 31'd7);
		send_word(mpi_pkg::OP_POW, 63'd5, 63'd0, 31'h7FFF_FFFF);
		send_word(mpi_pkg::OP_POW, '1, '1, 31'h7FFF_FFFF);
		send_word(mpi_pkg::OP_POW, '1, '1, 31'd2);
		send_word(mpi_pkg::OP_POW, 63'd2, 63'd30, 31'h7FFF_FFFF);
		send_word(mpi_pkg::OP_POW, 63'd1, 63'd1, 31'd3);
		send_word(mpi_pkg::OP_POW, '1, 63'd1, 31'd4);
		send_word(mpi_pkg::OP_POW, 63'd1000003, 63'd5, 31'd1000003);
		send_word(mpi_pkg::OP_POW, 63'd123456789, '1, 31'h4000_0000);
		send_word(mpi_pkg::OP_INV, 63'd3, '1, 31'd2);
		send_word(mpi_pkg::OP_INV, 63'd0, 63'd0, 31'd13);
		send_word(mpi_pkg::OP_INV, 63'd65, 63'd7, 31'd13);
		send_word(mpi_pkg::OP_INV, 63'd2, 63'd0, 31'd3);
		send_word(mpi_pkg::OP_INV, 63'd3, 63'd0, 31'd1000000007);
		send_word(mpi_pkg::OP_INV, '1, '1, 31'h7FFF_FFFF);
		send_word(mpi_pkg::OP_INV, 63'd4, 63'd9, 31'd15);
		send_word(mpi_pkg::OP_POW, 63'd5, 63'd3, 31'd0);
		send_word(mpi_pkg::OP_INV, 63'd5, 63'd3, 31'd0);
		send_word(mpi_pkg::OP_POW, '1, '1, 31'd1);
		send_word(mpi_pkg::OP_INV, 63'd7, 63'd0, 31'd1);

		for (int i = 0; i < NUM_ITEMS; i++) begin
			if (i == 500)
				hold_req = 1'b1;
			if (i == 1000) begin
				in_valid = 1'b0;
				wait (pending == 0);
				repeat ($urandom_range(20, 100)) @(negedge clk);
			end
			steady_send = (i >= 150 && i < 300) || (i >= 1100 && i < 1200);
			make_item(o, b, e, m);
			send_word(o, b, e, m);
		end
		in_valid = 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);

		$display("Checked %0d results: %0d powers (%0d with exponents over 32 bits),",
			checked_count, n_pow, n_long_exp);
		$display("%0d inverses, %0d with modulus below two, %0d failures",
			n_inv, n_mod_small, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
